>>> hdl/spd_pkg.sv
// shared constants and decode helpers for the safe path percent decoder
package spd_pkg;

	localparam int unsigned CountW = 15;

	// escape progress
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_PCT  = 2'd1;
	localparam logic [1:0] PH_HIGH = 2'd2;

	// first decode error of a path
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_ESC    = 2'd2;
	localparam logic [1:0] ERR_UNSAFE = 2'd3;

	// final status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TOO_LONG  = 3'd1;
	localparam logic [2:0] ST_BAD_ESC   = 3'd2;
	localparam logic [2:0] ST_UNSAFE    = 3'd3;
	localparam logic [2:0] ST_MALFORMED = 3'd4;

	localparam logic [CountW-1:0] COUNT_SAT  = '1;
	localparam logic [CountW-1:0] MAX_RESET  = 15'd16384;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_DEL   = 8'h7f;
	localparam logic [7:0] CH_CTL   = 8'h1f;

	// bit 4 is the valid flag, bits 3:0 the nibble
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

	// empty segment, "." or ".."
	function automatic logic seg_is_bad(input logic [1:0] len, input logic all_dots);
		return (len == 2'd0) || (all_dots && len != 2'd3);
	endfunction

endpackage

>>> hdl/safe_path_percent_decoder_top.sv
// safe path percent decoder: input stage, per-path state and result register
// path: a byte is registered in the input stage, then its result in the result register
// throughput: one byte per cycle when not stalled; the input stage and result register
// each hold one item, so while a result is stalled one more byte can still enter
// bytes that give no result (a '%' or an escape digit) pass through the input stage too
// reset: arst_n clears all path state, both stages, and sets the length limit to 16384
module safe_path_percent_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [14:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        out_byte_valid,
	output logic        path_done,
	output logic [2:0]  status
);

	logic [14:0] max_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	logic [1:0]  phase_q;
	logic [3:0]  high_q;
	logic [14:0] cnt_q;
	logic        any_q;
	logic [1:0]  err_q;
	logic [1:0]  seg_len_q;
	logic        seg_dots_q;
	logic        seg_bad_q;

	logic [1:0]  phase_d;
	logic [3:0]  high_d;
	logic [14:0] cnt_d;
	logic        any_d;
	logic [1:0]  err_d;
	logic [1:0]  seg_len_d;
	logic        seg_dots_d;
	logic        seg_bad_d;

	logic [7:0]  ch;
	logic        have;
	logic        escaped;
	logic        emit;
	logic        too_long;
	logic [4:0]  hex;
	logic [2:0]  st_d;
	logic        adv;
	logic        produce;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!out_valid || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign produce   = emit || last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= spd_pkg::MAX_RESET;
		end else if (cfg_valid) begin
			max_q <= cfg_data;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		high_d     = high_q;
		any_d      = any_q;
		err_d      = err_q;
		seg_len_d  = seg_len_q;
		seg_dots_d = seg_dots_q;
		seg_bad_d  = seg_bad_q;
		ch         = '0;
		have       = 1'b0;
		escaped    = 1'b0;
		emit       = 1'b0;
		st_d       = spd_pkg::ST_OK;
		hex        = spd_pkg::hex_value(byte_s1);
		cnt_d      = (cnt_q != spd_pkg::COUNT_SAT) ? cnt_q + 15'd1 : cnt_q;
		too_long   = cnt_d > max_q;

		if (!too_long && err_q == spd_pkg::ERR_NONE) begin
			case (phase_q)
				spd_pkg::PH_IDLE: begin
					if (byte_s1 == spd_pkg::CH_PCT) begin
						phase_d = spd_pkg::PH_PCT;
					end else begin
						ch   = byte_s1;
						have = 1'b1;
					end
				end
				spd_pkg::PH_PCT: begin
					if (hex[4]) begin
						high_d  = hex[3:0];
						phase_d = spd_pkg::PH_HIGH;
					end else begin
						err_d   = spd_pkg::ERR_ESC;
						phase_d = spd_pkg::PH_IDLE;
					end
				end
				default: begin
					if (hex[4]) begin
						ch      = {high_q, hex[3:0]};
						escaped = 1'b1;
						have    = 1'b1;
					end else begin
						err_d = spd_pkg::ERR_ESC;
					end
					phase_d = spd_pkg::PH_IDLE;
				end
			endcase

			if (have) begin
				if (ch <= spd_pkg::CH_CTL || ch == spd_pkg::CH_DEL || ch == spd_pkg::CH_BSL ||
						(ch == spd_pkg::CH_SLASH && (escaped || !any_q))) begin
					err_d = spd_pkg::ERR_UNSAFE;
				end else begin
					emit  = 1'b1;
					any_d = 1'b1;
					if (ch == spd_pkg::CH_SLASH) begin
						if (spd_pkg::seg_is_bad(seg_len_q, seg_dots_q)) begin
							seg_bad_d = 1'b1;
						end
						seg_len_d  = 2'd0;
						seg_dots_d = 1'b1;
					end else begin
						if (seg_len_q != 2'd3) begin
							seg_len_d = seg_len_q + 2'd1;
						end
						if (ch != spd_pkg::CH_DOT) begin
							seg_dots_d = 1'b0;
						end
					end
				end
			end
		end

		if (last_s1) begin
			if (too_long) begin
				st_d = spd_pkg::ST_TOO_LONG;
			end else if (err_d != spd_pkg::ERR_NONE) begin
				st_d = {1'b0, err_d};
			end else if (phase_d != spd_pkg::PH_IDLE) begin
				st_d = spd_pkg::ST_BAD_ESC;
			end else if (seg_bad_d || spd_pkg::seg_is_bad(seg_len_d, seg_dots_d)) begin
				st_d = spd_pkg::ST_MALFORMED;
			end
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// per-path state, back to reset values after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= spd_pkg::PH_IDLE;
			high_q     <= '0;
			cnt_q      <= '0;
			any_q      <= 1'b0;
			err_q      <= spd_pkg::ERR_NONE;
			seg_len_q  <= '0;
			seg_dots_q <= 1'b1;
			seg_bad_q  <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				phase_q    <= spd_pkg::PH_IDLE;
				high_q     <= '0;
				cnt_q      <= '0;
				any_q      <= 1'b0;
				err_q      <= spd_pkg::ERR_NONE;
				seg_len_q  <= '0;
				seg_dots_q <= 1'b1;
				seg_bad_q  <= 1'b0;
			end else begin
				phase_q    <= phase_d;
				high_q     <= high_d;
				cnt_q      <= cnt_d;
				any_q      <= any_d;
				err_q      <= err_d;
				seg_len_q  <= seg_len_d;
				seg_dots_q <= seg_dots_d;
				seg_bad_q  <= seg_bad_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv && produce) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && produce) begin
			out_byte       <= emit ? ch : 8'd0;
			out_byte_valid <= emit;
			path_done      <= last_s1;
			status         <= st_d;
		end
	end

	a_result_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_byte_valid || path_done))
		else $error("result with neither byte nor done");

	a_status_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !path_done) |-> (status == spd_pkg::ST_OK))
		else $error("status set on a non-final result");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_byte_valid) |-> (out_byte == 8'd0))
		else $error("byte not zero without a decoded byte");

	a_error_no_escape: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != spd_pkg::ERR_NONE) |-> (phase_q == spd_pkg::PH_IDLE))
		else $error("escape pending after a decode error");

	a_path_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (cnt_q == 15'd0 && err_q == spd_pkg::ERR_NONE && !any_q))
		else $error("path state not cleared after last byte");

endmodule

>>> sim/tb_safe_path_percent_decoder_top.sv
// testbench for the safe path percent decoder: directed paths, then random paths
`timescale 1ns / 100ps

module tb_safe_path_percent_decoder_top;

	typedef struct packed {
		logic [7:0] ob;
		logic       obv;
		logic       done;
		logic [2:0] st;
	} dec_res_t;

	typedef struct packed {
		logic [7:0] b;
		logic       l;
		logic       typed;
		dec_res_t   r;
	} dir_row_t;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 8;
	localparam int IDLE_GAP       = 4;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 45;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [14:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  in_byte;
	logic        in_last;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic        out_byte_valid;
	logic        path_done;
	logic [2:0]  status;

	// decoder state as the block should hold it
	logic [14:0] lim;
	logic [1:0]  esc_phase;
	logic [3:0]  hi_nib;
	logic [14:0] raw_cnt;
	logic        any_out;
	logic [1:0]  first_err;
	logic [1:0]  seg_len;
	logic        seg_dots;
	logic        seg_bad;

	dec_res_t    decoded_q[$];
	dir_row_t    dir_rows[$];
	logic [7:0]  path_q[$];

	int          snd_idle;
	int          rcv_idle;
	int          n_bad = 0;
	int          stall_cnt = 0;
	int          cfg_vals[PHASES] = '{16384, 3, 0, 32767, 1, 12, 5, 20};

	logic        in_take;
	logic        out_take;
	logic        cfg_take;
	dec_res_t    out_seen;

	safe_path_percent_decoder_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_byte        (in_byte),
		.in_last        (in_last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.out_byte_valid (out_byte_valid),
		.path_done      (path_done),
		.status         (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic clear_path();
		esc_phase = spd_pkg::PH_IDLE;
		hi_nib    = '0;
		raw_cnt   = '0;
		any_out   = 1'b0;
		first_err = spd_pkg::ERR_NONE;
		seg_len   = '0;
		seg_dots  = 1'b1;
		seg_bad   = 1'b0;
	endtask

	task automatic hex_digit(input logic [7:0] c, output logic ok, output logic [3:0] v);
		ok = 1'b1;
		v  = '0;
		if (c >= "0" && c <= "9") begin
			v = 4'(c - "0");
		end else if (c >= "A" && c <= "F") begin
			v = 4'(c - "A" + 8'd10);
		end else if (c >= "a" && c <= "f") begin
			v = 4'(c - "a" + 8'd10);
		end else begin
			ok = 1'b0;
		end
	endtask

	function automatic logic cur_seg_bad();
		return (seg_len == 2'd0) || (seg_dots && seg_len < 2'd3);
	endfunction

	// one raw byte through the decoder; has tells whether a result comes out
	task automatic decode_step(input logic [7:0] b, input logic l, output logic has,
			output dec_res_t r);
		logic [7:0] ch;
		logic [3:0] nib;
		logic       ok;
		logic       got;
		logic       esc;
		logic       emit;
		logic [2:0] st;
		ch   = '0;
		got  = 1'b0;
		esc  = 1'b0;
		emit = 1'b0;
		st   = spd_pkg::ST_OK;
		if (raw_cnt != 15'h7fff) raw_cnt = raw_cnt + 15'd1;
		if (raw_cnt <= lim && first_err == spd_pkg::ERR_NONE) begin
			if (esc_phase == spd_pkg::PH_IDLE) begin
				if (b == spd_pkg::CH_PCT) esc_phase = spd_pkg::PH_PCT;
				else begin
					ch  = b;
					got = 1'b1;
				end
			end else if (esc_phase == spd_pkg::PH_PCT) begin
				hex_digit(b, ok, nib);
				if (ok) begin
					hi_nib    = nib;
					esc_phase = spd_pkg::PH_HIGH;
				end else begin
					first_err = spd_pkg::ERR_ESC;
					esc_phase = spd_pkg::PH_IDLE;
				end
			end else begin
				hex_digit(b, ok, nib);
				if (ok) begin
					ch  = {hi_nib, nib};
					esc = 1'b1;
					got = 1'b1;
				end else begin
					first_err = spd_pkg::ERR_ESC;
				end
				esc_phase = spd_pkg::PH_IDLE;
			end
			if (got) begin
				if (ch <= spd_pkg::CH_CTL || ch == spd_pkg::CH_DEL || ch == spd_pkg::CH_BSL ||
						(esc && ch == spd_pkg::CH_SLASH) ||
						(ch == spd_pkg::CH_SLASH && !any_out)) begin
					first_err = spd_pkg::ERR_UNSAFE;
				end else begin
					emit    = 1'b1;
					any_out = 1'b1;
					if (ch == spd_pkg::CH_SLASH) begin
						if (cur_seg_bad()) seg_bad = 1'b1;
						seg_len  = '0;
						seg_dots = 1'b1;
					end else begin
						if (seg_len != 2'd3) seg_len = seg_len + 2'd1;
						if (ch != spd_pkg::CH_DOT) seg_dots = 1'b0;
					end
				end
			end
		end
		if (l) begin
			if (raw_cnt > lim) st = spd_pkg::ST_TOO_LONG;
			else if (first_err == spd_pkg::ERR_ESC) st = spd_pkg::ST_BAD_ESC;
			else if (first_err == spd_pkg::ERR_UNSAFE) st = spd_pkg::ST_UNSAFE;
			else if (esc_phase != spd_pkg::PH_IDLE) st = spd_pkg::ST_BAD_ESC;
			else if (seg_bad || cur_seg_bad()) st = spd_pkg::ST_MALFORMED;
			clear_path();
		end
		has = emit || l;
		r   = '{ob: emit ? ch : 8'h00, obv: emit, done: l, st: st};
	endtask

	// offer one byte, wait for the request to be taken, then record what should come out
	task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
			input dec_res_t tr);
		logic     rdy;
		logic     has;
		dec_res_t r;
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= l;
		rdy = 1'b0;
		while (!rdy) begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end
		decode_step(b, l, has, r);
		if (typed) decoded_q = {decoded_q, tr};
		else if (has) decoded_q = {decoded_q, r};
	endtask

	task automatic send_path();
		for (int i = 0; i < path_q.size(); i++) begin
			send_byte(path_q[i], i == path_q.size() - 1, 1'b0, '0);
		end
	endtask

	// hold off until every result is out and the pipeline has emptied
	task automatic drain();
		in_valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	task automatic write_limit(input logic [14:0] v);
		logic rdy;
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		rdy = 1'b0;
		while (!rdy) begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		lim = v;
	endtask

	task automatic dir_pred(input logic [7:0] b, input logic l);
		dir_row_t row;
		row = '{b: b, l: l, typed: 1'b0, r: '0};
		dir_rows = {dir_rows, row};
	endtask

	task automatic dir_exp(input logic [7:0] b, input logic l, input logic [7:0] ob,
			input logic obv, input logic done, input logic [2:0] st);
		dir_row_t row;
		row = '{b: b, l: l, typed: 1'b1, r: '{ob: ob, obv: obv, done: done, st: st}};
		dir_rows = {dir_rows, row};
	endtask

	function automatic logic [7:0] safe_char();
		int k;
		k = $urandom_range(9);
		if (k == 0) return spd_pkg::CH_DOT;
		if (k <= 4) return 8'("a" + $urandom_range(25));
		if (k <= 6) return 8'("A" + $urandom_range(25));
		if (k <= 8) return 8'("0" + $urandom_range(9));
		return $urandom_range(1) ? 8'h5f : 8'h7e;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) return 8'("0" + v);
		return 8'(($urandom_range(1) ? "a" : "A") + v - 4'd10);
	endfunction

	task automatic add_seg();
		logic [7:0] c;
		int         len;
		len = $urandom_range(4, 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(4) == 0) begin
				c = ($urandom_range(3) == 0) ? 8'($urandom_range(255, 128)) : safe_char();
				path_q = {path_q, spd_pkg::CH_PCT};
				path_q = {path_q, hex_char(c[7:4])};
				path_q = {path_q, hex_char(c[3:0])};
			end else begin
				path_q = {path_q, safe_char()};
			end
		end
	endtask

	task automatic build_path();
		int         kind;
		int         nseg;
		int         len;
		logic [7:0] nb;
		path_q.delete();
		kind = $urandom_range(99);
		if (kind < 15) begin
			// noise, with plenty of escape starts
			len = $urandom_range(10, 1);
			for (int i = 0; i < len; i++) begin
				nb = ($urandom_range(4) == 0) ? spd_pkg::CH_PCT : 8'($urandom_range(255));
				path_q = {path_q, nb};
			end
		end else begin
			nseg = $urandom_range(3, 1);
			for (int s = 0; s < nseg; s++) begin
				if (s > 0) path_q = {path_q, spd_pkg::CH_SLASH};
				add_seg();
			end
			if (kind >= 85) begin
				case ($urandom_range(9))
					0: path_q[$urandom_range(path_q.size() - 1)] = 8'($urandom_range(31));
					1: path_q[$urandom_range(path_q.size() - 1)] = spd_pkg::CH_DEL;
					2: path_q[$urandom_range(path_q.size() - 1)] = spd_pkg::CH_BSL;
					3: path_q = {path_q, spd_pkg::CH_PCT};
					4: begin
						path_q = {path_q, spd_pkg::CH_PCT};
						path_q = {path_q, hex_char(4'($urandom_range(15)))};
						path_q = {path_q, 8'("g")};
						add_seg();
					end
					5: begin
						// escaped slash
						path_q = {path_q, spd_pkg::CH_PCT};
						path_q = {path_q, 8'("2")};
						path_q = {path_q, hex_char(4'hf)};
						add_seg();
					end
					6: path_q = {path_q, spd_pkg::CH_SLASH};
					7: path_q.push_front(spd_pkg::CH_SLASH);
					8: begin
						path_q = {path_q, spd_pkg::CH_SLASH};
						path_q = {path_q, spd_pkg::CH_DOT};
						if ($urandom_range(1)) path_q = {path_q, spd_pkg::CH_DOT};
					end
					default: begin
						path_q = {path_q, spd_pkg::CH_SLASH};
						path_q = {path_q, spd_pkg::CH_SLASH};
						add_seg();
					end
				endcase
			end
		end
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rcv_idle);
	end

	// sample the handshakes mid-cycle; they are taken at the next rising edge
	always @(negedge clk) begin
		in_take  = in_valid && in_ready;
		cfg_take = cfg_valid && cfg_ready;
		out_take = out_valid && out_ready;
		out_seen = '{ob: out_byte, obv: out_byte_valid, done: path_done, st: status};
	end

	always @(posedge clk) begin
		dec_res_t want;
		if (out_take) begin
			if (decoded_q.size() == 0) begin
				$display("%0t: unexpected result: got byte %h valid %b done %b status %0d",
					$time, out_seen.ob, out_seen.obv, out_seen.done, out_seen.st);
				n_bad++;
			end else begin
				want = decoded_q.pop_front();
				if (out_seen !== want) begin
					$display("%0t: result differs: ", $time,
						"expected byte %h valid %b done %b status %0d, ",
						want.ob, want.obv, want.done, want.st,
						"got byte %h valid %b done %b status %0d",
						out_seen.ob, out_seen.obv, out_seen.done, out_seen.st);
					n_bad++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (in_take || out_take || cfg_take) stall_cnt <= 0;
		else stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= WATCHDOG_LIMIT) begin
			$display("%0t: no request moved for %0d cycles", $time, stall_cnt);
			$display("safe_path_percent_decoder_top: mismatch");
			$finish;
		end
	end

	initial begin
		int n;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_byte   = '0;
		in_last   = 1'b0;
		snd_idle  = 10;
		rcv_idle  = 54;
		lim       = spd_pkg::MAX_RESET;
		clear_path();

		// each path starts fresh; limit is at its reset value
		dir_exp("a", 1'b1, "a", 1'b1, 1'b1, spd_pkg::ST_OK);
		dir_exp(8'h00, 1'b1, 8'h00, 1'b0, 1'b1, spd_pkg::ST_UNSAFE);
		dir_exp(8'hff, 1'b1, 8'hff, 1'b1, 1'b1, spd_pkg::ST_OK);
		dir_exp(spd_pkg::CH_DEL, 1'b1, 8'h00, 1'b0, 1'b1, spd_pkg::ST_UNSAFE);
		dir_exp(spd_pkg::CH_SLASH, 1'b1, 8'h00, 1'b0, 1'b1, spd_pkg::ST_UNSAFE);
		dir_exp(spd_pkg::CH_DOT, 1'b1, spd_pkg::CH_DOT, 1'b1, 1'b1, spd_pkg::ST_MALFORMED);
		// upper case escape, then an escaped slash, then a byte that is dropped
		dir_pred(spd_pkg::CH_PCT, 1'b0);
		dir_pred("4", 1'b0);
		dir_pred("1", 1'b0);
		dir_pred(spd_pkg::CH_PCT, 1'b0);
		dir_pred("2", 1'b0);
		dir_pred("f", 1'b0);
		dir_exp("b", 1'b1, 8'h00, 1'b0, 1'b1, spd_pkg::ST_UNSAFE);
		// non-hex digit
		dir_pred(spd_pkg::CH_PCT, 1'b0);
		dir_pred("g", 1'b0);
		dir_exp("x", 1'b1, 8'h00, 1'b0, 1'b1, spd_pkg::ST_BAD_ESC);
		// escape cut off by the last byte
		dir_pred("a", 1'b0);
		dir_exp(spd_pkg::CH_PCT, 1'b1, 8'h00, 1'b0, 1'b1, spd_pkg::ST_BAD_ESC);
		dir_pred("a", 1'b0);
		dir_exp(spd_pkg::CH_BSL, 1'b1, 8'h00, 1'b0, 1'b1, spd_pkg::ST_UNSAFE);
		// parent segment
		dir_pred("a", 1'b0);
		dir_pred(spd_pkg::CH_SLASH, 1'b0);
		dir_pred(spd_pkg::CH_DOT, 1'b0);
		dir_exp(spd_pkg::CH_DOT, 1'b1, spd_pkg::CH_DOT, 1'b1, 1'b1, spd_pkg::ST_MALFORMED);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_byte(dir_rows[i].b, dir_rows[i].l, dir_rows[i].typed, dir_rows[i].r);
		end

		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_limit(15'(cfg_vals[p]));
			if (p < 3) begin
				snd_idle = 10;
				rcv_idle = 54;
			end else if (p < 6) begin
				snd_idle = 54;
				rcv_idle = 10;
			end else begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			n = 0;
			while (n < PHASE_ITEMS) begin
				build_path();
				send_path();
				n += path_q.size();
			end
		end

		in_valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_bad == 0 && decoded_q.size() == 0) begin
			$display("safe_path_percent_decoder_top: match");
		end else begin
			$display("safe_path_percent_decoder_top: mismatch");
		end
		$finish;
	end

endmodule
